FILE: src/tqlf_pkg.sv
// shared constants, codes and controller/datapath interface types
package tqlf_pkg;

  // queue and batch sizing
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_BATCH   = 16;
  localparam int ID_BITS     = 10;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int REM_W   = $clog2(MAX_BATCH + 1);
  localparam int BATCH_W = 5;

  localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(10);

  // stream payload widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;

  // input command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // direction codes
  localparam logic DIR_NORTH = 1'b0;
  localparam logic DIR_SOUTH = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_GRANT  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic arrive;
    logic idle_res;
    logic tick_start;
    logic pop;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic queues_empty;
    logic batch_last;
  } dp_status_t;

endpackage

FILE: src/two_queue_longest_first_batch_arbiter.sv
// top level of the two-queue longest-first batch arbiter
//
// Input stream: each transaction is an arrive (tuser 0) that pushes an id into
// the north or south queue, or a tick (tuser 1) that grants one queue and pops
// a batch from it. The output stream carries one result per arrive, one per
// popped id on a tick (tlast on the final one), or one idle result on a tick
// with both queues empty. North is granted only when it is strictly longer.
// An arrive or idle result is registered on acceptance and shows in the cycle
// after. A tick passes through the fetch state, then the drain state pops its
// ids (up to 16) one per cycle while the result register is free; the block
// takes no new input until the last id is popped. The pop rate is set by the one
// registered read port of each queue ram, which is read one entry ahead.
// cfg_we_i loads batch_limit (0 acts as 1, values above 16 act as 16).
// Reset empties both queues and sets batch_limit to 10; the queue rams are not
// cleared. When the receiver stalls, the result register holds and the block
// stops popping and stops accepting input until the result is taken.
module two_queue_longest_first_batch_arbiter
  import tqlf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // vehicle_id[9:0], direction[10], zero pad
  input  logic [0:0]           s_axis_tuser,  // command[0]
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // granted_id[9:0], granted_dir[10],
                                              // north_count[17:11], south_count[24:18], zero pad
  output logic [1:0]           m_axis_tuser,  // kind[1:0]
  output logic                 m_axis_tlast,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [BATCH_W-1:0]   cfg_wdata_i
);

  localparam int OUT_USED_W = ID_BITS + 1 + 2 * CNT_W;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  kind_e              out_kind;
  logic [ID_BITS-1:0] out_id;
  logic               out_dir;
  logic [CNT_W-1:0]   out_ncnt, out_scnt;

  // controller
  tqlf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_tick_i (s_axis_tuser[0]),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath
  tqlf_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_id_i    (s_axis_tdata[ID_BITS-1:0]),
    .in_dir_i   (s_axis_tdata[ID_BITS]),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_kind_o (out_kind),
    .out_id_o   (out_id),
    .out_dir_o  (out_dir),
    .out_last_o (m_axis_tlast),
    .out_ncnt_o (out_ncnt),
    .out_scnt_o (out_scnt)
  );

  // stream packing
  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {{(M_TDATA_W - OUT_USED_W){1'b0}}, out_scnt, out_ncnt, out_dir, out_id};

endmodule

FILE: src/tqlf_ram.sv
// generic single-write, single-read ram with registered read data
module tqlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tqlf_ctrl.sv
// controller state machine: sequences arrive, idle and batch drain transactions
module tqlf_ctrl
  import tqlf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_tick_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free && (in_tick_i == CMD_TICK) &&
            !status_i.queues_empty) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.out_free && status_i.batch_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          if (in_tick_i == CMD_ARRIVE) begin
            cmd_o.arrive = 1'b1;
          end else if (status_i.queues_empty) begin
            cmd_o.idle_res = 1'b1;
          end else begin
            cmd_o.tick_start = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd_o = '0;
      end
      ST_DRAIN: begin
        cmd_o.pop = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: src/tqlf_dp.sv
// datapath: queue pointers and counts, id rams, grant choice and result register
module tqlf_dp
  import tqlf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic [ID_BITS-1:0] in_id_i,
  input  logic               in_dir_i,
  input  logic               cfg_we_i,
  input  logic [BATCH_W-1:0] cfg_wdata_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output kind_e              out_kind_o,
  output logic [ID_BITS-1:0] out_id_o,
  output logic               out_dir_o,
  output logic               out_last_o,
  output logic [CNT_W-1:0]   out_ncnt_o,
  output logic [CNT_W-1:0]   out_scnt_o
);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  logic [BATCH_W-1:0] batch_limit_q;
  logic [PTR_W-1:0]   n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [PTR_W-1:0]   s_head_q, s_head_d, s_tail_q, s_tail_d;
  logic [CNT_W-1:0]   n_occ_q, n_occ_d, s_occ_q, s_occ_d;
  logic               gdir_q, gdir_d;
  logic [REM_W-1:0]   rem_q, rem_d;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  logic [ID_BITS-1:0] out_id_q, out_id_d;
  logic               out_dir_q, out_dir_d;
  logic               out_last_q, out_last_d;
  logic [CNT_W-1:0]   out_ncnt_q, out_scnt_q;

  logic               out_free, load;
  logic               n_full, s_full, arr_full;
  logic               n_we, s_we, n_pop, s_pop;
  logic [PTR_W-1:0]   n_raddr, s_raddr;
  logic [ID_BITS-1:0] n_rdata, s_rdata;
  logic [REM_W-1:0]   lim_sat, rem_init;
  logic               grant_south;
  logic [CNT_W-1:0]   g_occ;

  // batch limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_limit_q <= BATCH_RESET;
    end else if (cfg_we_i) begin
      batch_limit_q <= cfg_wdata_i;
    end
  end

  // status back to the controller
  assign out_free = !out_valid_q || out_ready_i;
  assign status_o.out_free     = out_free;
  assign status_o.queues_empty = (n_occ_q == '0) && (s_occ_q == '0);
  assign status_o.batch_last   = (rem_q == REM_W'(1));

  // full flags and ram strobes
  assign n_full   = (n_occ_q == CNT_W'(QUEUE_DEPTH));
  assign s_full   = (s_occ_q == CNT_W'(QUEUE_DEPTH));
  assign arr_full = (in_dir_i == DIR_SOUTH) ? s_full : n_full;
  assign n_we     = cmd_i.arrive && (in_dir_i == DIR_NORTH) && !n_full;
  assign s_we     = cmd_i.arrive && (in_dir_i == DIR_SOUTH) && !s_full;
  assign n_pop    = cmd_i.pop && (gdir_q == DIR_NORTH);
  assign s_pop    = cmd_i.pop && (gdir_q == DIR_SOUTH);

  // read one entry ahead so each drain cycle with the result register free pops one id
  assign n_raddr = n_pop ? next_ptr(n_head_q) : n_head_q;
  assign s_raddr = s_pop ? next_ptr(s_head_q) : s_head_q;

  tqlf_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_north_ram (
    .clk_i  (clk_i),
    .we_i   (n_we),
    .waddr_i(n_tail_q),
    .wdata_i(in_id_i),
    .raddr_i(n_raddr),
    .rdata_o(n_rdata)
  );

  tqlf_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_south_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_tail_q),
    .wdata_i(in_id_i),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  // grant choice and batch size: north only when strictly longer
  always_comb begin
    priority if (batch_limit_q == '0) begin
      lim_sat = REM_W'(1);
    end else if (32'(batch_limit_q) > MAX_BATCH) begin
      lim_sat = REM_W'(MAX_BATCH);
    end else begin
      lim_sat = REM_W'(batch_limit_q);
    end
    grant_south = !(n_occ_q > s_occ_q) && (s_occ_q != '0);
    g_occ       = grant_south ? s_occ_q : n_occ_q;
    rem_init    = (32'(g_occ) < 32'(lim_sat)) ? REM_W'(g_occ) : lim_sat;
  end

  // pointer, count and batch bookkeeping
  always_comb begin
    n_head_d = n_pop ? next_ptr(n_head_q) : n_head_q;
    s_head_d = s_pop ? next_ptr(s_head_q) : s_head_q;
    n_tail_d = n_we ? next_ptr(n_tail_q) : n_tail_q;
    s_tail_d = s_we ? next_ptr(s_tail_q) : s_tail_q;
    n_occ_d  = n_occ_q;
    s_occ_d  = s_occ_q;
    if (n_we) begin
      n_occ_d = n_occ_q + 1'b1;
    end else if (n_pop) begin
      n_occ_d = n_occ_q - 1'b1;
    end
    if (s_we) begin
      s_occ_d = s_occ_q + 1'b1;
    end else if (s_pop) begin
      s_occ_d = s_occ_q - 1'b1;
    end
    gdir_d = gdir_q;
    rem_d  = rem_q;
    if (cmd_i.tick_start) begin
      gdir_d = grant_south ? DIR_SOUTH : DIR_NORTH;
      rem_d  = rem_init;
    end else if (cmd_i.pop) begin
      rem_d = rem_q - 1'b1;
    end
  end

  // result register contents
  assign load = cmd_i.arrive || cmd_i.idle_res || cmd_i.pop;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    priority if (cmd_i.pop) begin
      out_kind_d = KIND_GRANT;
      out_id_d   = (gdir_q == DIR_SOUTH) ? s_rdata : n_rdata;
      out_dir_d  = gdir_q;
      out_last_d = (rem_q == REM_W'(1));
    end else if (cmd_i.arrive) begin
      out_kind_d = arr_full ? KIND_DROP : KIND_ACCEPT;
      out_id_d   = '0;
      out_dir_d  = in_dir_i;
      out_last_d = 1'b1;
    end else begin
      out_kind_d = KIND_IDLE;
      out_id_d   = '0;
      out_dir_d  = DIR_NORTH;
      out_last_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_head_q    <= '0;
      n_tail_q    <= '0;
      n_occ_q     <= '0;
      s_head_q    <= '0;
      s_tail_q    <= '0;
      s_occ_q     <= '0;
      gdir_q      <= DIR_NORTH;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_head_q    <= n_head_d;
      n_tail_q    <= n_tail_d;
      n_occ_q     <= n_occ_d;
      s_head_q    <= s_head_d;
      s_tail_q    <= s_tail_d;
      s_occ_q     <= s_occ_d;
      gdir_q      <= gdir_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_dir_q  <= out_dir_d;
      out_last_q <= out_last_d;
      out_ncnt_q <= n_occ_d;
      out_scnt_q <= s_occ_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_dir_o   = out_dir_q;
  assign out_last_o  = out_last_q;
  assign out_ncnt_o  = out_ncnt_q;
  assign out_scnt_o  = out_scnt_q;

endmodule

FILE: src/tqlf_checker.sv
// port-level checker for the arbiter, bound to the top level
module tqlf_checker
  import tqlf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]           m_axis_tuser,
  input logic                 m_axis_tlast
);

  localparam int NCNT_LO = ID_BITS + 1;
  localparam int SCNT_LO = ID_BITS + 1 + CNT_W;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // an input is taken only when the result register has room
  a_in_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken while result stalled");

  // arrive, drop and idle results always end their transaction
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_GRANT) |-> m_axis_tlast)
    else $error("single result without tlast");

  // only granted entries carry an id
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_GRANT) |-> (m_axis_tdata[ID_BITS-1:0] == '0))
    else $error("non-grant result with id");

  // occupancies never exceed the queue depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[NCNT_LO +: CNT_W] <= CNT_W'(QUEUE_DEPTH)) &&
      (m_axis_tdata[SCNT_LO +: CNT_W] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count out of range");

endmodule

bind two_queue_longest_first_batch_arbiter tqlf_checker u_tqlf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
